/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each check is clocked on aclk and
// is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCDC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SCDC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SCDC_ASSERT_IMP(name, ante, cons)
`define SCDC_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* rtl/core/scdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo colour distance cost package
// Widths, register codes and payload types shared by the cost datapath.
// ----------------------------------------------------------------------------
package scdc_pkg;

    localparam int WIN_DEPTH      = 128;
    localparam int WIN_AW         = $clog2(WIN_DEPTH);
    localparam int CNT_W          = $clog2(WIN_DEPTH + 1);
    localparam int MAX_LAYERS     = 64;
    localparam int LAYER_W        = $clog2(MAX_LAYERS);
    localparam int COST_FRAC_BITS = 4;

    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int DISP_W   = 7;
    localparam int COST_W   = 12;
    localparam int OFF_W    = ((DISP_W > LAYER_W) ? DISP_W : LAYER_W) + 1;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int RAD_W    = SUM_W + 2 * COST_FRAC_BITS;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int DIV_SH   = ROOT_W + 2;
    localparam int DIV_MW   = DIV_SH - 1;
    localparam int DIV_MUL  = (2 ** DIV_SH) / 3 + 1;
    localparam int PROD_W   = ROOT_W + DIV_MW;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [DISP_W-1:0] MAX_DISP_RST = DISP_W'(64);
    localparam logic [DISP_W-1:0] MIN_DISP_RST = DISP_W'(0);
    localparam logic [COST_W-1:0] THRESH_RST   = COST_W'(3200);

    typedef enum logic [1:0] {
        REG_MAX_DISP = 2'd0,
        REG_MIN_DISP = 2'd1,
        REG_THRESH   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] left_red;
        logic [CHAN_W-1:0] left_green;
        logic [CHAN_W-1:0] left_blue;
        logic [CHAN_W-1:0] right_red;
        logic [CHAN_W-1:0] right_green;
        logic [CHAN_W-1:0] right_blue;
        logic              row_start;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [LAYER_W-1:0] layer;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic             en;
        logic             row_start;
        logic [PIX_W-1:0] pixel;
    } win_wr_t;

    typedef struct packed {
        logic              en;
        logic [WIN_AW-1:0] off;
    } win_rd_t;

    typedef struct packed {
        logic               vld;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [LAYER_W-1:0] layer;
        logic               last;
    } root_cell_t;

endpackage

/* rtl/core/scdc_root_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root: brings down two radicand
// bits and settles one root bit, then hands the partial result on.
// ----------------------------------------------------------------------------
module scdc_root_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  scdc_pkg::root_cell_t  cell_i,
    output scdc_pkg::root_cell_t  cell_o
);

    scdc_pkg::root_cell_t cell_reg;
    scdc_pkg::root_cell_t cell_next;
    logic                 vld_reg;
    logic [scdc_pkg::REM_W-1:0] rem_sh;
    logic [scdc_pkg::REM_W-1:0] trial;

    always_comb begin
        rem_sh = {cell_i.rem[scdc_pkg::REM_W-3:0],
                  cell_i.rad[scdc_pkg::RAD_W-1:scdc_pkg::RAD_W-2]};
        trial  = {{(scdc_pkg::REM_W-scdc_pkg::ROOT_W-2){1'b0}}, cell_i.root, 2'b01};
        cell_next     = cell_i;
        cell_next.rad = {cell_i.rad[scdc_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_i.root[scdc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_i.root[scdc_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= cell_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    always_comb begin
        cell_o     = cell_reg;
        cell_o.vld = vld_reg;
    end

endmodule

/* rtl/core/scdc_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Right pixel window
// Circular store of recent right pixels. A fill count and the first pixel
// of the row stand in for clamping the entries before column zero.
// ----------------------------------------------------------------------------
module scdc_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  scdc_pkg::win_wr_t            wr,
    input  scdc_pkg::win_rd_t            rd,
    output logic [scdc_pkg::PIX_W-1:0]   rd_pixel
);

    logic [scdc_pkg::PIX_W-1:0]  mem [scdc_pkg::WIN_DEPTH];
    logic [scdc_pkg::WIN_AW-1:0] wp_reg;
    logic [scdc_pkg::WIN_AW-1:0] wp_next;
    logic [scdc_pkg::CNT_W-1:0]  cnt_reg;
    logic [scdc_pkg::CNT_W-1:0]  cnt_next;
    logic [scdc_pkg::PIX_W-1:0]  first_reg;
    logic [scdc_pkg::PIX_W-1:0]  mem_q_reg;
    logic [scdc_pkg::PIX_W-1:0]  first_q_reg;
    logic                        sel_first_reg;

    assign wp_next = wp_reg + 1'b1;

    always_comb begin
        if (wr.row_start) begin
            cnt_next = scdc_pkg::CNT_W'(1);
        end else if (cnt_reg == scdc_pkg::CNT_W'(scdc_pkg::WIN_DEPTH)) begin
            cnt_next = cnt_reg;
        end else begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Before any row start, entries beyond the fill count read as zero, as after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            cnt_reg   <= '0;
            first_reg <= '0;
        end else if (wr.en) begin
            wp_reg  <= wp_next;
            cnt_reg <= cnt_next;
            if (wr.row_start) begin
                first_reg <= wr.pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wp_next] <= wr.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            mem_q_reg     <= mem[wp_reg - rd.off];
            first_q_reg   <= first_reg;
            sel_first_reg <= ({1'b0, rd.off} >= cnt_reg);
        end
    end

    assign rd_pixel = sel_first_reg ? first_q_reg : mem_q_reg;

endmodule

/* rtl/core/stereo_color_distance_cost.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo colour distance cost
// Euclidean RGB matching cost per disparity layer over a right pixel window.
// ----------------------------------------------------------------------------
// A pixel pair issues span + 1 layers, where span is max_disparity -
// min_disparity held at least 1 and at most 63: the request is taken
// first, then the layer sequencer issues one window read per cycle and
// frees the input once the last layer of the current one is issued.
// Costs leave in layer order, one per cycle, through stages 0, 1 and 2, a
// row of square root cells settling one root bit each, divider and output.
// A stalled result holds the whole pipeline and the sequencer with it.
// No clearing pass follows reset.
module stereo_color_distance_cost (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  scdc_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output scdc_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scdc_pkg::CFG_AW-1:0]   paddr,
    input  logic [scdc_pkg::CFG_DW-1:0]   pwdata,
    output logic [scdc_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
`include "assert_macros.svh"

    logic [scdc_pkg::DISP_W-1:0] max_disp_reg;
    logic [scdc_pkg::DISP_W-1:0] min_disp_reg;
    logic [scdc_pkg::COST_W-1:0] thresh_reg;
    scdc_pkg::reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = scdc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_disp_reg <= scdc_pkg::MAX_DISP_RST;
            min_disp_reg <= scdc_pkg::MIN_DISP_RST;
            thresh_reg   <= scdc_pkg::THRESH_RST;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                scdc_pkg::REG_MAX_DISP: max_disp_reg <= pwdata[scdc_pkg::DISP_W-1:0];
                scdc_pkg::REG_MIN_DISP: min_disp_reg <= pwdata[scdc_pkg::DISP_W-1:0];
                scdc_pkg::REG_THRESH:   thresh_reg   <= pwdata[scdc_pkg::COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            scdc_pkg::REG_MAX_DISP:
                prdata = {{(scdc_pkg::CFG_DW-scdc_pkg::DISP_W){1'b0}}, max_disp_reg};
            scdc_pkg::REG_MIN_DISP:
                prdata = {{(scdc_pkg::CFG_DW-scdc_pkg::DISP_W){1'b0}}, min_disp_reg};
            scdc_pkg::REG_THRESH:
                prdata = {{(scdc_pkg::CFG_DW-scdc_pkg::COST_W){1'b0}}, thresh_reg};
            default: prdata = '0;
        endcase
    end

    // The whole datapath moves together; it stops only while a result waits.
    logic pipe_en;
    logic accept;
    assign pipe_en = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    // Layer sequencer.
    logic                         busy_reg;
    logic [scdc_pkg::LAYER_W-1:0] d_reg;
    logic [scdc_pkg::LAYER_W-1:0] span_reg;
    logic [scdc_pkg::LAYER_W-1:0] span_next;
    logic [scdc_pkg::PIX_W-1:0]   left_reg;
    logic [scdc_pkg::DISP_W:0]    diff_w;
    logic [scdc_pkg::OFF_W-1:0]   off_w;
    logic                         issue;

    assign s_ready = !busy_reg;
    assign issue   = busy_reg && pipe_en;

    always_comb begin
        if ({1'b0, max_disp_reg} > ({1'b0, min_disp_reg} + 1'b1)) begin
            diff_w = {1'b0, max_disp_reg} - {1'b0, min_disp_reg};
        end else begin
            diff_w = (scdc_pkg::DISP_W+1)'(1);
        end
        if (diff_w > (scdc_pkg::DISP_W+1)'(scdc_pkg::MAX_LAYERS - 1)) begin
            span_next = scdc_pkg::LAYER_W'(scdc_pkg::MAX_LAYERS - 1);
        end else begin
            span_next = diff_w[scdc_pkg::LAYER_W-1:0];
        end
        off_w = scdc_pkg::OFF_W'(min_disp_reg) + scdc_pkg::OFF_W'(d_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            d_reg    <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            d_reg    <= '0;
        end else if (issue) begin
            d_reg <= d_reg + 1'b1;
            if (d_reg == span_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            span_reg <= span_next;
            left_reg <= {s_data.left_red, s_data.left_green, s_data.left_blue};
        end
    end

    scdc_pkg::win_wr_t            win_wr;
    scdc_pkg::win_rd_t            win_rd;
    logic [scdc_pkg::PIX_W-1:0]   right_pix;

    always_comb begin
        win_wr.en        = accept;
        win_wr.row_start = s_data.row_start;
        win_wr.pixel     = {s_data.right_red, s_data.right_green, s_data.right_blue};
        win_rd.en        = issue;
        if (off_w > scdc_pkg::OFF_W'(scdc_pkg::WIN_DEPTH - 1)) begin
            win_rd.off = scdc_pkg::WIN_AW'(scdc_pkg::WIN_DEPTH - 1);
        end else begin
            win_rd.off = off_w[scdc_pkg::WIN_AW-1:0];
        end
    end

    scdc_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (win_wr),
        .rd       (win_rd),
        .rd_pixel (right_pix)
    );

    // Stage 0 runs alongside the window read.
    logic                         s0_vld_reg;
    logic [scdc_pkg::LAYER_W-1:0] s0_layer_reg;
    logic                         s0_last_reg;
    logic [scdc_pkg::PIX_W-1:0]   s0_left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_vld_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_layer_reg <= d_reg;
            s0_last_reg  <= (d_reg == span_reg);
            s0_left_reg  <= left_reg;
        end
    end

    // Stage 1: squared channel differences.
    logic [scdc_pkg::CHAN_W-1:0]  ad [3];
    logic [scdc_pkg::SQ_W-1:0]    s1_sq_reg [3];
    logic                         s1_vld_reg;
    logic [scdc_pkg::LAYER_W-1:0] s1_layer_reg;
    logic                         s1_last_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (s0_left_reg[c*scdc_pkg::CHAN_W +: scdc_pkg::CHAN_W]
                    > right_pix[c*scdc_pkg::CHAN_W +: scdc_pkg::CHAN_W]) begin
                ad[c] = s0_left_reg[c*scdc_pkg::CHAN_W +: scdc_pkg::CHAN_W]
                        - right_pix[c*scdc_pkg::CHAN_W +: scdc_pkg::CHAN_W];
            end else begin
                ad[c] = right_pix[c*scdc_pkg::CHAN_W +: scdc_pkg::CHAN_W]
                        - s0_left_reg[c*scdc_pkg::CHAN_W +: scdc_pkg::CHAN_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int c = 0; c < 3; c++) begin
                s1_sq_reg[c] <= scdc_pkg::SQ_W'(ad[c]) * scdc_pkg::SQ_W'(ad[c]);
            end
            s1_layer_reg <= s0_layer_reg;
            s1_last_reg  <= s0_last_reg;
        end
    end

    // Stage 2: radicand with the fraction bits brought in, then the root cells.
    logic [scdc_pkg::SUM_W-1:0] sum_w;
    scdc_pkg::root_cell_t       cell_in;
    scdc_pkg::root_cell_t       chain [scdc_pkg::ROOT_W+1];

    always_comb begin
        sum_w = scdc_pkg::SUM_W'(s1_sq_reg[0]) + scdc_pkg::SUM_W'(s1_sq_reg[1])
                + scdc_pkg::SUM_W'(s1_sq_reg[2]);
        cell_in.vld   = s1_vld_reg;
        cell_in.rad   = scdc_pkg::RAD_W'(sum_w) << (2 * scdc_pkg::COST_FRAC_BITS);
        cell_in.rem   = '0;
        cell_in.root  = '0;
        cell_in.layer = s1_layer_reg;
        cell_in.last  = s1_last_reg;
    end

    logic s2_vld_reg;
    scdc_pkg::root_cell_t s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_vld_reg <= cell_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_reg <= cell_in;
        end
    end

    always_comb begin
        chain[0]     = s2_reg;
        chain[0].vld = s2_vld_reg;
    end

    for (genvar i = 0; i < scdc_pkg::ROOT_W; i++) begin : g_cell
        scdc_root_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .cell_i  (chain[i]),
            .cell_o  (chain[i+1])
        );
    end

    // Division by three as a multiplication by the reciprocal.
    logic                         dv_vld_reg;
    logic [scdc_pkg::PROD_W-1:0]  dv_prod_reg;
    logic [scdc_pkg::LAYER_W-1:0] dv_layer_reg;
    logic                         dv_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            dv_vld_reg <= chain[scdc_pkg::ROOT_W].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dv_prod_reg  <= scdc_pkg::PROD_W'(chain[scdc_pkg::ROOT_W].root)
                            * scdc_pkg::PROD_W'(scdc_pkg::DIV_MUL);
            dv_layer_reg <= chain[scdc_pkg::ROOT_W].layer;
            dv_last_reg  <= chain[scdc_pkg::ROOT_W].last;
        end
    end

    logic [scdc_pkg::ROOT_W-1:0]               quot;
    logic [scdc_pkg::ROOT_W+scdc_pkg::COST_W-1:0] quot_x;
    logic [scdc_pkg::ROOT_W+scdc_pkg::COST_W-1:0] thr_x;
    logic [scdc_pkg::COST_W-1:0]               cost_w;

    always_comb begin
        quot   = scdc_pkg::ROOT_W'(dv_prod_reg >> scdc_pkg::DIV_SH);
        quot_x = {{scdc_pkg::COST_W{1'b0}}, quot};
        thr_x  = {{scdc_pkg::ROOT_W{1'b0}}, thresh_reg};
        if (quot_x > thr_x) begin
            cost_w = thresh_reg;
        end else begin
            cost_w = quot_x[scdc_pkg::COST_W-1:0];
        end
    end

    logic                out_vld_reg;
    scdc_pkg::out_item_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            out_vld_reg <= dv_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_reg.cost  <= cost_w;
            out_reg.layer <= dv_layer_reg;
            out_reg.last  <= dv_last_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    `SCDC_ASSERT_NXT(a_accept_starts, accept, busy_reg && (d_reg == '0))
    `SCDC_ASSERT_NXT(a_issue_ends, issue && (d_reg == span_reg), !busy_reg)
    `SCDC_ASSERT_IMP(a_layer_bound, busy_reg, d_reg <= span_reg)

endmodule
